### rtl/core/ntl_pkg.sv
// Shared types and constants for the NTC trimmed-mean temperature lookup unit.
// No dependencies; used by the top level and its checker.
`default_nettype none

package ntl_pkg;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_UPPER_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOWER_LIMIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ENTRIES     = 2'd2;

    localparam logic [15:0] UPPER_LIMIT_RESET = 16'hFFFF;
    localparam logic [15:0] LOWER_LIMIT_RESET = 16'h0000;
    localparam logic [7:0]  ENTRIES_RESET     = 8'd101;

    // Field widths fixed by the interface
    localparam int RES_W    = 16;
    localparam int TEMP_W   = 7;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 3;

    localparam logic [COUNT_W-1:0] GROUP_LEN  = 3'd7;
    localparam logic [TEMP_W-1:0]  TEMP_RESET = 7'd26;
    localparam logic [RES_W-1:0]   RES_MAX    = 16'hFFFF;

    localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_HIGH = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_LOW  = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_AVG,
        S_DIV,
        S_LIMIT,
        S_CHK_HI,
        S_CHK_LO,
        S_MID,
        S_CHK_MID,
        S_CHK_NEXT,
        S_DONE
    } state_t;

endpackage

`default_nettype wire

### rtl/core/ntc_trimmed_mean_temperature_lookup_unit.sv
// NTC thermistor lookup: trimmed mean of ADC samples, resistance divider,
// binary search over a loaded resistance table. Depends on ntl_pkg.
//
//   Channel   Signals                                          Direction
//   --------  -----------------------------------------------  ---------
//   in        in_valid/in_ready, mode, sample_code,            sink
//             entry_index, entry_value
//   out       out_valid/out_ready, average_code,               source
//             resistance_kohm, temperature_index, status
//   cfg       cfg_we, cfg_index, cfg_data (no wait, no read)   sink
//
// Sample and table-load items are taken one per cycle while idle. The item
// closing a group of seven leaves idle: the trimmed average, the bit-serial
// restoring divider, the limit check and, inside the limits, reads of the
// table ends and then of bisection midpoints through the single table read
// port follow; no item is taken until the result enters the output register.
// Reset restores the group, the limits and last temperature; the table holds
// garbage until loaded. A stalled result waits in the output register while
// new samples are still taken; only a second finished group waits for it.
`default_nettype none

module ntc_trimmed_mean_temperature_lookup_unit #(
    parameter int TABLE_DEPTH = 128,
    parameter int ADC_BITS    = 12
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,

    input  wire logic                                 in_valid,
    output logic                                      in_ready,
    input  wire logic                                 mode,
    input  wire logic [ADC_BITS-1:0]                  sample_code,
    input  wire logic [$clog2(TABLE_DEPTH)-1:0]       entry_index,
    input  wire logic [ntl_pkg::RES_W-1:0]            entry_value,

    output logic                                      out_valid,
    input  wire logic                                 out_ready,
    output logic [ADC_BITS-1:0]                       average_code,
    output logic [ntl_pkg::RES_W-1:0]                 resistance_kohm,
    output logic [ntl_pkg::TEMP_W-1:0]                temperature_index,
    output logic [ntl_pkg::STATUS_W-1:0]              status,

    input  wire logic                                 cfg_we,
    input  wire logic [ntl_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [ntl_pkg::CFG_DATA_W-1:0]       cfg_data
);

    localparam int AW   = $clog2(TABLE_DEPTH);
    localparam int SW   = ADC_BITS + 3;          // sum of six samples
    localparam int Q_W  = ADC_BITS + 4;          // 10*avg and quotient
    localparam int D_W  = ADC_BITS + 1;          // divisor
    localparam int R_W  = ADC_BITS + 2;          // partial remainder
    localparam int DC_W = $clog2(Q_W + 1);
    localparam int QE_W = (Q_W > ntl_pkg::RES_W) ? Q_W : ntl_pkg::RES_W + 1;
    localparam int CW   = ((AW > 8) ? AW : 8) + 2; // signed search bounds

    localparam logic [ADC_BITS-1:0]   CODE_MASK = {ADC_BITS{1'b1}};
    localparam logic [D_W-1:0]        FULL_SCALE = {1'b1, {ADC_BITS{1'b0}}};
    localparam logic signed [CW-1:0]  N_MIN = CW'(2);
    localparam logic signed [CW-1:0]  N_MAX = CW'(TABLE_DEPTH);
    localparam logic [DC_W-1:0]       DIV_LAST = DC_W'(Q_W - 1);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [ntl_pkg::RES_W-1:0] upper_reg;
    logic [ntl_pkg::RES_W-1:0] lower_reg;
    logic [7:0]                entries_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upper_reg   <= ntl_pkg::UPPER_LIMIT_RESET;
            lower_reg   <= ntl_pkg::LOWER_LIMIT_RESET;
            entries_reg <= ntl_pkg::ENTRIES_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                ntl_pkg::REG_UPPER_LIMIT: upper_reg   <= cfg_data;
                ntl_pkg::REG_LOWER_LIMIT: lower_reg   <= cfg_data;
                ntl_pkg::REG_ENTRIES:     entries_reg <= cfg_data[7:0];
                default:                  ; // unmapped index: drop the write
            endcase
        end
    end

    // Number of entries searched, clamped to [2, TABLE_DEPTH]
    logic signed [CW-1:0] eu_ext;
    logic signed [CW-1:0] n_c;

    always_comb
    begin
        eu_ext = $signed(CW'(entries_reg));
        if (eu_ext < N_MIN)
            n_c = N_MIN;
        else if (eu_ext > N_MAX)
            n_c = N_MAX;
        else
            n_c = eu_ext;
    end

    // ------------------------------------------------------------------
    // Table memory: one write port, one registered read port
    // ------------------------------------------------------------------
    logic [ntl_pkg::RES_W-1:0] table_mem [TABLE_DEPTH];
    logic [ntl_pkg::RES_W-1:0] rd_data_reg;
    logic [AW-1:0]             rd_addr;
    logic                      wr_en;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            table_mem[entry_index] <= entry_value;
        rd_data_reg <= table_mem[rd_addr];
    end

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    ntl_pkg::state_t state_reg, state_next;

    logic [ntl_pkg::COUNT_W-1:0] count_reg, count_next;
    logic [SW-1:0]               sum_reg, sum_next;
    logic [ADC_BITS-1:0]         min_reg, min_next;
    logic [ADC_BITS-1:0]         max_reg, max_next;
    logic [ntl_pkg::TEMP_W-1:0]  last_temp_reg, last_temp_next;
    logic                        out_valid_reg, out_valid_next;

    logic [ADC_BITS-1:0]          avg_reg, avg_next;
    logic [Q_W-1:0]               num_reg, num_next;
    logic [D_W-1:0]               den_reg, den_next;
    logic [R_W-1:0]               rem_reg, rem_next;
    logic [DC_W-1:0]              div_cnt_reg, div_cnt_next;
    logic [ntl_pkg::RES_W-1:0]    res_reg, res_next;
    logic [ntl_pkg::STATUS_W-1:0] status_reg, status_next;
    logic signed [CW-1:0]         lo_reg, lo_next;
    logic signed [CW-1:0]         hi_reg, hi_next;
    logic signed [CW-1:0]         mid_reg, mid_next;
    logic [ntl_pkg::RES_W-1:0]    tmid_reg, tmid_next;

    logic [ADC_BITS-1:0]          out_avg_reg, out_avg_next;
    logic [ntl_pkg::RES_W-1:0]    out_res_reg, out_res_next;
    logic [ntl_pkg::TEMP_W-1:0]   out_temp_reg, out_temp_next;
    logic [ntl_pkg::STATUS_W-1:0] out_status_reg, out_status_next;

    // Datapath helpers
    logic [SW-1:0]        trim_c;
    logic [ADC_BITS-1:0]  avg_c;
    logic [Q_W-1:0]       avg_q;
    logic [R_W-1:0]       trial_c;
    logic                 qbit_c;
    logic [QE_W-1:0]      q_ext;
    logic [ntl_pkg::RES_W-1:0] res_c;
    logic signed [CW-1:0] sum_lh;
    logic signed [CW-1:0] mid_c;
    logic signed [CW-1:0] mid_inc;
    logic signed [CW-1:0] mid_dec;
    logic signed [CW-1:0] hi_init;
    logic                 idx_ok;
    logic                 in_fire;

    assign in_ready = (state_reg == ntl_pkg::S_IDLE);
    assign in_fire  = in_valid && in_ready;
    assign idx_ok   = ({1'b0, entry_index} < (AW + 1)'(TABLE_DEPTH));

    // Drop both extremes, divide by four
    assign trim_c  = sum_reg - SW'(min_reg) - SW'(max_reg);
    assign avg_c   = trim_c[ADC_BITS+1:2];
    assign avg_q   = Q_W'(avg_c);

    // One restoring-division step
    assign trial_c = {rem_reg[R_W-2:0], num_reg[Q_W-1]};
    assign qbit_c  = (trial_c >= R_W'(den_reg));

    // Saturate quotient to 16 bits
    assign q_ext   = QE_W'(num_reg);
    assign res_c   = (q_ext > QE_W'(ntl_pkg::RES_MAX)) ? ntl_pkg::RES_MAX
                                                       : q_ext[ntl_pkg::RES_W-1:0];

    assign sum_lh  = lo_reg + hi_reg;
    assign mid_c   = sum_lh >>> 1;
    assign mid_inc = mid_reg + CW'(1);
    assign mid_dec = mid_reg - CW'(1);
    assign hi_init = n_c - CW'(1);

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        sum_next        = sum_reg;
        min_next        = min_reg;
        max_next        = max_reg;
        last_temp_next  = last_temp_reg;
        out_valid_next  = out_valid_reg;
        avg_next        = avg_reg;
        num_next        = num_reg;
        den_next        = den_reg;
        rem_next        = rem_reg;
        div_cnt_next    = div_cnt_reg;
        res_next        = res_reg;
        status_next     = status_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        mid_next        = mid_reg;
        tmid_next       = tmid_reg;
        out_avg_next    = out_avg_reg;
        out_res_next    = out_res_reg;
        out_temp_next   = out_temp_reg;
        out_status_next = out_status_reg;
        rd_addr         = '0;
        wr_en           = 1'b0;

        // Retire a delivered result
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ntl_pkg::S_IDLE:
            begin
                if (in_fire)
                begin
                    if (mode)
                    begin
                        wr_en = idx_ok;
                    end
                    else
                    begin
                        // First sample of a group is thrown away
                        if (count_reg != '0)
                        begin
                            sum_next = sum_reg + SW'(sample_code);
                            if (sample_code > max_reg)
                                max_next = sample_code;
                            if (sample_code < min_reg)
                                min_next = sample_code;
                        end
                        count_next = count_reg + 1'b1;
                        if (count_reg == ntl_pkg::GROUP_LEN - 1'b1)
                            state_next = ntl_pkg::S_AVG;
                    end
                end
            end

            ntl_pkg::S_AVG:
            begin
                avg_next     = avg_c;
                num_next     = (avg_q << 3) + (avg_q << 1);
                den_next     = FULL_SCALE - D_W'(avg_c);
                rem_next     = '0;
                div_cnt_next = '0;
                count_next   = '0;
                sum_next     = '0;
                min_next     = CODE_MASK;
                max_next     = '0;
                state_next   = ntl_pkg::S_DIV;
            end

            ntl_pkg::S_DIV:
            begin
                rem_next     = qbit_c ? (trial_c - R_W'(den_reg)) : trial_c;
                num_next     = {num_reg[Q_W-2:0], qbit_c};
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_cnt_reg == DIV_LAST)
                    state_next = ntl_pkg::S_LIMIT;
            end

            ntl_pkg::S_LIMIT:
            begin
                res_next = res_c;
                if (res_c >= upper_reg)
                begin
                    status_next = ntl_pkg::STATUS_HIGH;
                    state_next  = ntl_pkg::S_DONE;
                end
                else if (res_c <= lower_reg)
                begin
                    status_next = ntl_pkg::STATUS_LOW;
                    state_next  = ntl_pkg::S_DONE;
                end
                else
                begin
                    status_next = ntl_pkg::STATUS_OK;
                    lo_next     = '0;
                    hi_next     = hi_init;
                    rd_addr     = hi_init[AW-1:0];
                    state_next  = ntl_pkg::S_CHK_HI;
                end
            end

            ntl_pkg::S_CHK_HI:
            begin
                // At or hotter than the last used entry: clamp to it
                if (res_reg <= rd_data_reg)
                begin
                    last_temp_next = ntl_pkg::TEMP_W'(hi_reg[AW-1:0]);
                    state_next     = ntl_pkg::S_DONE;
                end
                else
                begin
                    rd_addr    = '0;
                    state_next = ntl_pkg::S_CHK_LO;
                end
            end

            ntl_pkg::S_CHK_LO:
            begin
                // At or colder than the first entry: clamp to index zero
                if (res_reg >= rd_data_reg)
                begin
                    last_temp_next = '0;
                    state_next     = ntl_pkg::S_DONE;
                end
                else
                begin
                    state_next = ntl_pkg::S_MID;
                end
            end

            ntl_pkg::S_MID:
            begin
                if (lo_reg > hi_reg)
                begin
                    // No bracketing pair found
                    last_temp_next = '0;
                    state_next     = ntl_pkg::S_DONE;
                end
                else
                begin
                    mid_next   = mid_c;
                    rd_addr    = mid_c[AW-1:0];
                    state_next = ntl_pkg::S_CHK_MID;
                end
            end

            ntl_pkg::S_CHK_MID:
            begin
                tmid_next = rd_data_reg;
                if (mid_inc < n_c)
                begin
                    rd_addr    = mid_inc[AW-1:0];
                    state_next = ntl_pkg::S_CHK_NEXT;
                end
                else
                begin
                    if (res_reg < rd_data_reg)
                        lo_next = mid_inc;
                    else
                        hi_next = mid_dec;
                    state_next = ntl_pkg::S_MID;
                end
            end

            ntl_pkg::S_CHK_NEXT:
            begin
                if ((res_reg <= tmid_reg) && (res_reg >= rd_data_reg))
                begin
                    last_temp_next = ntl_pkg::TEMP_W'(mid_reg[AW-1:0]);
                    state_next     = ntl_pkg::S_DONE;
                end
                else
                begin
                    if (res_reg < tmid_reg)
                        lo_next = mid_inc;
                    else
                        hi_next = mid_dec;
                    state_next = ntl_pkg::S_MID;
                end
            end

            ntl_pkg::S_DONE:
            begin
                // Hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    out_avg_next    = avg_reg;
                    out_res_next    = res_reg;
                    out_temp_next   = last_temp_reg;
                    out_status_next = status_reg;
                    out_valid_next  = 1'b1;
                    state_next      = ntl_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = ntl_pkg::S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ntl_pkg::S_IDLE;
            count_reg     <= '0;
            sum_reg       <= '0;
            min_reg       <= CODE_MASK;
            max_reg       <= '0;
            last_temp_reg <= ntl_pkg::TEMP_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            sum_reg       <= sum_next;
            min_reg       <= min_next;
            max_reg       <= max_next;
            last_temp_reg <= last_temp_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        avg_reg        <= avg_next;
        num_reg        <= num_next;
        den_reg        <= den_next;
        rem_reg        <= rem_next;
        div_cnt_reg    <= div_cnt_next;
        res_reg        <= res_next;
        status_reg     <= status_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        mid_reg        <= mid_next;
        tmid_reg       <= tmid_next;
        out_avg_reg    <= out_avg_next;
        out_res_reg    <= out_res_next;
        out_temp_reg   <= out_temp_next;
        out_status_reg <= out_status_next;
    end

    assign out_valid         = out_valid_reg;
    assign average_code      = out_avg_reg;
    assign resistance_kohm   = out_res_reg;
    assign temperature_index = out_temp_reg;
    assign status            = out_status_reg;

endmodule

`default_nettype wire

### rtl/core/ntl_checker.sv
// Port-level checks for the NTC lookup unit, bound onto the top level.
// Depends on ntl_pkg.
`default_nettype none

module ntl_checker #(
    parameter int ADC_BITS    = 12
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            out_valid,
    input  wire logic                            out_ready,
    input  wire logic [ADC_BITS-1:0]             average_code,
    input  wire logic [ntl_pkg::RES_W-1:0]       resistance_kohm,
    input  wire logic [ntl_pkg::TEMP_W-1:0]      temperature_index,
    input  wire logic [ntl_pkg::STATUS_W-1:0]    status
);

    // Temperature of the last delivered item
    logic [ntl_pkg::TEMP_W-1:0] seen_temp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            seen_temp_reg <= ntl_pkg::TEMP_RESET;
        else if (out_valid && out_ready)
            seen_temp_reg <= temperature_index;
    end

    // A stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(average_code)
            && $stable(resistance_kohm) && $stable(temperature_index) && $stable(status))
        else $error("result changed while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == ntl_pkg::STATUS_OK) || (status == ntl_pkg::STATUS_HIGH)
            || (status == ntl_pkg::STATUS_LOW))
        else $error("undefined status code");

    // A fault keeps the previous temperature
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != ntl_pkg::STATUS_OK) |-> temperature_index == seen_temp_reg)
        else $error("temperature changed on a fault result");

    // An ok result never sits at either rail of the resistance range
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ntl_pkg::STATUS_OK)
            |-> (resistance_kohm != '0) && (resistance_kohm != ntl_pkg::RES_MAX))
        else $error("ok status with resistance at a rail");

endmodule

bind ntc_trimmed_mean_temperature_lookup_unit ntl_checker #(
    .ADC_BITS(ADC_BITS)
) u_ntl_checker (
    .clk(clk),
    .rst_n(rst_n),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .average_code(average_code),
    .resistance_kohm(resistance_kohm),
    .temperature_index(temperature_index),
    .status(status)
);

`default_nettype wire

### tb/tb_ntc_trimmed_mean_temperature_lookup_unit.sv
`timescale 1ns / 1ps
// Testbench for the NTC trimmed-mean temperature lookup unit: directed and random items,
// each result checked against a predictor kept in this file.
// Depends on ntl_pkg and ntc_trimmed_mean_temperature_lookup_unit.

module tb_ntc_trimmed_mean_temperature_lookup_unit;

    localparam int   DEPTH          = 128;
    localparam int   CODE_MAX       = 4095;
    localparam int   FULL_SCALE     = 4096;
    localparam int   ITEM_TARGET    = 1250;
    // Extra wait after draining; leaves headroom over a closing sample's work.
    localparam int   SETTLE_CYCLES  = 100;
    localparam int   RX_HOLD_CYCLES = 600;
    localparam logic MODE_SAMPLE    = 1'b0;
    localparam logic MODE_LOAD      = 1'b1;

    typedef enum int {SHAPE_DESCENDING, SHAPE_PLATEAU, SHAPE_SCRAMBLED} table_shape_t;

    typedef struct packed {
        logic [11:0]                  avg;
        logic [ntl_pkg::RES_W-1:0]    res;
        logic [ntl_pkg::TEMP_W-1:0]   temp;
        logic [ntl_pkg::STATUS_W-1:0] stat;
    } reading_t;

    // Block ports; every input starts at a known value.
    logic                           clk         = 1'b0;
    logic                           rst_n       = 1'b0;
    logic                           in_valid    = 1'b0;
    logic                           in_ready;
    logic                           mode        = MODE_SAMPLE;
    logic [11:0]                    sample_code = '0;
    logic [6:0]                     entry_index = '0;
    logic [ntl_pkg::RES_W-1:0]      entry_value = '0;
    logic                           out_valid;
    logic                           out_ready   = 1'b0;
    logic [11:0]                    average_code;
    logic [ntl_pkg::RES_W-1:0]      resistance_kohm;
    logic [ntl_pkg::TEMP_W-1:0]     temperature_index;
    logic [ntl_pkg::STATUS_W-1:0]   status;
    logic                           cfg_we      = 1'b0;
    logic [ntl_pkg::CFG_IDX_W-1:0]  cfg_index   = '0;
    logic [ntl_pkg::CFG_DATA_W-1:0] cfg_data    = '0;

    // Predictor state: registers, group accumulator, resistance table, held temperature.
    logic [15:0]                 lim_upper   = ntl_pkg::UPPER_LIMIT_RESET;
    logic [15:0]                 lim_lower   = ntl_pkg::LOWER_LIMIT_RESET;
    logic [7:0]                  entries_reg = ntl_pkg::ENTRIES_RESET;
    logic [ntl_pkg::COUNT_W-1:0] grp_count   = '0;
    logic [14:0]                 grp_sum     = '0;
    logic [11:0]                 grp_min     = 12'(CODE_MAX);
    logic [11:0]                 grp_max     = '0;
    logic [ntl_pkg::RES_W-1:0]   kohm_table [DEPTH];
    logic [ntl_pkg::TEMP_W-1:0]  held_temp   = ntl_pkg::TEMP_RESET;

    reading_t expected_readings [$];
    int       items_sent      = 0;
    int       error_count     = 0;
    // Idling controls shared by the stimulus and the result sink.
    bit       tx_no_gaps      = 1'b0;
    bit       rx_always_ready = 1'b0;
    int       rx_hold_request = 0;

    ntc_trimmed_mean_temperature_lookup_unit dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .mode              (mode),
        .sample_code       (sample_code),
        .entry_index       (entry_index),
        .entry_value       (entry_value),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .average_code      (average_code),
        .resistance_kohm   (resistance_kohm),
        .temperature_index (temperature_index),
        .status            (status),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Number of table entries the search covers, clamped the way the block clamps it.
    function automatic int searched_entries();
        int n;
        n = entries_reg;
        if (n < 2)
            n = 2;
        if (n > DEPTH)
            n = DEPTH;
        return n;
    endfunction

    // Bisection over the descending resistance table; clamps at both ends, and falls
    // back to index zero when no bracketing pair turns up (table out of order).
    function automatic logic [ntl_pkg::TEMP_W-1:0] bisect_kohm_table(input int key);
        int n, lo, hi, mid;
        n  = searched_entries();
        lo = 0;
        hi = n - 1;
        if (key <= int'(kohm_table[hi]))
            return ntl_pkg::TEMP_W'(hi);
        if (key >= int'(kohm_table[0]))
            return '0;
        while (lo <= hi)
        begin
            mid = (lo + hi) / 2;
            if (mid + 1 < n && key <= int'(kohm_table[mid]) &&
                key >= int'(kohm_table[mid + 1]))
                return ntl_pkg::TEMP_W'(mid);
            if (key < int'(kohm_table[mid]))
                lo = mid + 1;
            else
                hi = mid - 1;
        end
        return '0;
    endfunction

    // Advance the predictor by one accepted item; queue a reading when a group closes.
    task automatic predict_item(input logic m, input logic [11:0] code,
                                input logic [6:0] idx, input logic [15:0] val);
        int       trimmed, kohm;
        reading_t r;
        if (m == MODE_LOAD)
        begin
            kohm_table[idx] = val;
            return;
        end
        // The first sample of every group only opens the group.
        if (grp_count != 0)
        begin
            grp_sum = grp_sum + code;
            if (code > grp_max)
                grp_max = code;
            if (code < grp_min)
                grp_min = code;
        end
        grp_count = grp_count + 1'b1;
        if (grp_count < ntl_pkg::GROUP_LEN)
            return;

        // Drop both extremes, average the four in the middle.
        trimmed   = (int'(grp_sum) - int'(grp_min) - int'(grp_max)) >> 2;
        r.avg     = trimmed[11:0];
        grp_count = '0;
        grp_sum   = '0;
        grp_min   = 12'(CODE_MAX);
        grp_max   = '0;

        kohm = (10 * int'(r.avg)) / (FULL_SCALE - int'(r.avg));
        if (kohm > 65535)
            kohm = 65535;
        r.res = kohm[15:0];
        if (r.res >= lim_upper)
            r.stat = ntl_pkg::STATUS_HIGH;
        else if (r.res <= lim_lower)
            r.stat = ntl_pkg::STATUS_LOW;
        else
        begin
            r.stat    = ntl_pkg::STATUS_OK;
            held_temp = bisect_kohm_table(kohm);
        end
        r.temp = held_temp;
        expected_readings.push_back(r);
    endtask

    // Offer one item after a random gap; return at the edge that accepts it.
    // Valid stays high on return so that a back-to-back item follows without a bubble.
    task automatic send_item(input logic m, input logic [11:0] code,
                             input logic [6:0] idx, input logic [15:0] val);
        int gap, pick;
        pick = $urandom_range(0, 99);
        if (tx_no_gaps || pick < 65)
            gap = 0;
        else if (pick < 92)
            gap = $urandom_range(1, 3);
        else
            gap = $urandom_range(10, 40);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        mode        <= m;
        sample_code <= code;
        entry_index <= idx;
        entry_value <= val;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        items_sent++;
        predict_item(m, code, idx, val);
    endtask

    // Unused fields carry random bits so that every input bit toggles.
    task automatic send_sample(input logic [11:0] code);
        send_item(MODE_SAMPLE, code, 7'($urandom), 16'($urandom));
    endtask

    task automatic send_entry(input logic [6:0] idx, input logic [15:0] val);
        send_item(MODE_LOAD, 12'($urandom), idx, val);
    endtask

    // Drop valid and wait for every pending reading; always lets at least one edge pass.
    task automatic pause_for_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_readings.size() != 0);
    endtask

    // Drain, then hold off long enough for any table load still in the block to land.
    task automatic settle_block();
        pause_for_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write all three registers on consecutive edges while the block is idle.
    task automatic configure(input logic [15:0] upper, input logic [15:0] lower,
                             input logic [7:0] entries);
        settle_block();
        cfg_we    <= 1'b1;
        cfg_index <= ntl_pkg::REG_UPPER_LIMIT;
        cfg_data  <= upper;
        @(posedge clk);
        cfg_index <= ntl_pkg::REG_LOWER_LIMIT;
        cfg_data  <= lower;
        @(posedge clk);
        // Only the low byte counts for the entry count; the rest is noise.
        cfg_index <= ntl_pkg::REG_ENTRIES;
        cfg_data  <= {8'($urandom), entries};
        @(posedge clk);
        cfg_we      <= 1'b0;
        lim_upper   = upper;
        lim_lower   = lower;
        entries_reg = entries;
    endtask

    // Fill all 128 entries: an NTC-like falloff, the same with flat runs, or noise.
    task automatic load_table(input table_shape_t shape);
        int i, v;
        v = $urandom_range(38000, 45000);
        for (i = 0; i < DEPTH; i++)
        begin
            if (shape == SHAPE_SCRAMBLED)
                send_entry(7'(i), 16'($urandom));
            else
            begin
                send_entry(7'(i), v[15:0]);
                if (!(shape == SHAPE_PLATEAU && $urandom_range(0, 2) == 0))
                    v = v - (v >> 4) - $urandom_range(0, 3);
                if (v < 0)
                    v = 0;
            end
        end
    endtask

    // Rewrite one entry: half the time inside its neighbors' span, else anything.
    task automatic send_table_edit();
        int idx, lo, hi;
        idx = $urandom_range(0, DEPTH - 1);
        lo  = (idx < DEPTH - 1) ? int'(kohm_table[idx + 1]) : 0;
        hi  = (idx > 0) ? int'(kohm_table[idx - 1]) : 65535;
        if (lo <= hi && $urandom_range(0, 1) == 0)
            send_entry(7'(idx), 16'($urandom_range(lo, hi)));
        else
            send_entry(7'(idx), 16'($urandom));
    endtask

    // Center code for a group: mostly one that lands on or near a table entry.
    function automatic int pick_center();
        int pick, n, k, target, code;
        pick = $urandom_range(0, 99);
        if (pick >= 90)
            return $urandom_range(0, 1) * CODE_MAX;
        if (pick >= 80)
            return $urandom_range(3900, CODE_MAX);
        if (pick >= 60)
            return $urandom_range(0, CODE_MAX);
        n      = searched_entries();
        k      = $urandom_range(0, n - 1);
        target = int'(kohm_table[k]) + $urandom_range(0, 4) - 2;
        // Now and then push past either end of the searched range.
        if (pick < 5)
            target = int'(kohm_table[n - 1]) - $urandom_range(0, 50);
        else if (pick < 10)
            target = int'(kohm_table[0]) + $urandom_range(0, 5000);
        if (target < 0)
            target = 0;
        code = (FULL_SCALE * target) / (10 + target);
        if (code > CODE_MAX)
            code = CODE_MAX;
        return code;
    endfunction

    // One group of seven samples around a center; the opener is random since it is
    // dropped, an odd outlier tests the trimming, table edits may land mid-group.
    task automatic send_group(input int center, input int jitter, input bit with_loads);
        int s, v;
        send_sample(12'($urandom));
        for (s = 0; s < 6; s++)
        begin
            if (with_loads && $urandom_range(0, 2) == 0)
                send_table_edit();
            v = center + $urandom_range(0, 2 * jitter) - jitter;
            if ($urandom_range(0, 9) == 0)
                v = $urandom_range(0, CODE_MAX);
            if (v < 0)
                v = 0;
            if (v > CODE_MAX)
                v = CODE_MAX;
            send_sample(v[11:0]);
        end
    endtask

    task automatic send_uniform_group(input logic [11:0] opener, input logic [11:0] code);
        send_sample(opener);
        repeat (6) send_sample(code);
    endtask

    // A fault before any lookup must report the reset temperature.
    task automatic test_reset_hold_value();
        send_uniform_group(12'(CODE_MAX), 12'd0);
    endtask

    task automatic test_directed_extremes();
        // Full-scale group: the largest resistance, compared against the first entry.
        send_uniform_group(12'd0, 12'(CODE_MAX));
        // Both extremes inside the group get trimmed; table ends rewritten mid-group.
        send_sample(12'd2048);
        send_sample(12'd0);
        send_entry(7'd127, 16'h0000);
        send_sample(12'(CODE_MAX));
        send_entry(7'd0, 16'hFFFF);
        repeat (4) send_sample(12'd1000);
        // Same full-scale group, now bracketed below the first entry.
        send_uniform_group(12'd0, 12'(CODE_MAX));
    endtask

    // Limits at their extremes and right on the computed resistance:
    // code 2048 gives 10 kohm and code 2146 gives 11 kohm.
    task automatic test_limit_extremes();
        logic [15:0] uppers [6] = '{16'd0, 16'hFFFF, 16'd0, 16'd10, 16'd12, 16'd1000};
        logic [15:0] lowers [6] = '{16'd0, 16'hFFFF, 16'hFFFF, 16'd9, 16'd10, 16'd100};
        int i;
        for (i = 0; i < 6; i++)
        begin
            configure(uppers[i], lowers[i], entries_reg);
            send_uniform_group(12'($urandom), 12'd2048);
            send_uniform_group(12'($urandom), 12'd2146);
            send_group(pick_center(), 2, 1'b0);
        end
    endtask

    // Entry counts below 2 and above the depth are clamped by the block.
    task automatic test_entries_extremes();
        logic [7:0] counts [9] = '{8'd0, 8'd1, 8'd2, 8'd3, 8'd64, 8'd127, 8'd128, 8'd129,
                                   8'd255};
        int i;
        for (i = 0; i < 9; i++)
        begin
            configure(16'hFFFF, 16'h0000, counts[i]);
            repeat (3) send_group(pick_center(), 1, 1'b0);
        end
    endtask

    // Stall the sink for a long stretch while groups keep coming back to back:
    // the output register and the next finished group fill, then input stalls.
    task automatic test_output_backpressure();
        rx_hold_request = RX_HOLD_CYCLES;
        tx_no_gaps      = 1'b1;
        repeat (6) send_group(pick_center(), 2, 1'b0);
        tx_no_gaps      = 1'b0;
    endtask

    // Stop offering until every reading is back, several times over.
    task automatic test_sender_pause();
        repeat (4)
        begin
            send_group(pick_center(), 2, 1'b0);
            pause_for_results();
        end
    endtask

    // Phases of random register settings, table shapes and traffic mixes.
    task automatic test_random_traffic();
        int          phase, pick, g;
        logic [15:0] up, lo;
        logic [7:0]  n;
        phase = 0;
        while (items_sent < ITEM_TARGET)
        begin
            pick = $urandom_range(0, 9);
            up   = (pick < 3) ? 16'hFFFF :
                   (pick < 6) ? 16'($urandom_range(10, 2000)) : 16'($urandom);
            pick = $urandom_range(0, 9);
            lo   = (pick < 4) ? 16'h0000 :
                   (pick < 8) ? 16'($urandom_range(0, 200)) : 16'($urandom);
            pick = $urandom_range(0, 9);
            n    = (pick < 5) ? 8'd128 :
                   (pick < 8) ? 8'($urandom_range(2, DEPTH)) : 8'($urandom);
            configure(up, lo, n);
            if (phase % 3 == 2)
                load_table(table_shape_t'(((phase / 3) + 1) % 3));
            tx_no_gaps      = ($urandom_range(0, 3) == 0);
            rx_always_ready = ($urandom_range(0, 3) == 0);
            for (g = 0; g < 20 && items_sent < ITEM_TARGET; g++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 70)
                    send_group(pick_center(), $urandom_range(0, 3), 1'b0);
                else if (pick < 82)
                    repeat (7) send_sample(12'($urandom));
                else if (pick < 94)
                    send_group(pick_center(), $urandom_range(0, 40), 1'b1);
                else
                    send_table_edit();
                if ($urandom_range(0, 29) == 0)
                    pause_for_results();
            end
            phase++;
        end
        tx_no_gaps      = 1'b0;
        rx_always_ready = 1'b0;
    endtask

    // Result sink: check each accepted reading against the oldest prediction, then
    // pick out_ready for the next edge from random runs of ready and stall.
    initial
    begin : result_sink
        int       run_left, hold_left, pick;
        logic     level;
        reading_t want;
        run_left  = 0;
        hold_left = 0;
        level     = 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                if (expected_readings.size() == 0)
                begin
                    $error("result with no reading pending: average_code %0d", average_code);
                    error_count++;
                end
                else
                begin
                    want = expected_readings.pop_front();
                    if (average_code !== want.avg)
                    begin
                        $error("average_code: expected %0d, got %0d", want.avg, average_code);
                        error_count++;
                    end
                    if (resistance_kohm !== want.res)
                    begin
                        $error("resistance_kohm: expected %0d, got %0d",
                               want.res, resistance_kohm);
                        error_count++;
                    end
                    if (temperature_index !== want.temp)
                    begin
                        $error("temperature_index: expected %0d, got %0d",
                               want.temp, temperature_index);
                        error_count++;
                    end
                    if (status !== want.stat)
                    begin
                        $error("status: expected %0d, got %0d", want.stat, status);
                        error_count++;
                    end
                end
            end

            // Take a long hold-off when asked; count it here, cycle by cycle.
            if (rx_hold_request > 0)
            begin
                hold_left       = rx_hold_request;
                rx_hold_request = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                level = 1'b0;
            end
            else if (rx_always_ready)
                level = 1'b1;
            else
            begin
                if (run_left == 0)
                begin
                    pick = $urandom_range(0, 99);
                    if (pick < 55)
                    begin
                        level    = 1'b1;
                        run_left = $urandom_range(1, 16);
                    end
                    else if (pick < 90)
                    begin
                        level    = 1'b0;
                        run_left = $urandom_range(1, 3);
                    end
                    else
                    begin
                        level    = 1'b0;
                        run_left = $urandom_range(15, 60);
                    end
                end
                run_left--;
            end
            out_ready <= level;
        end
    end

    // Stimulus: reset once, then each test in turn, then the verdict.
    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_hold_value();
        // Load the whole table before any lookup can read it.
        load_table(SHAPE_DESCENDING);
        test_directed_extremes();
        test_limit_extremes();
        test_entries_extremes();
        test_output_backpressure();
        test_sender_pause();
        test_random_traffic();

        settle_block();
        if (error_count == 0)
            $display("ntc_trimmed_mean_temperature_lookup_unit test passed");
        else
            $display("ntc_trimmed_mean_temperature_lookup_unit test failed");
        $finish;
    end

    // Hard stop well beyond the slowest legal run.
    initial
    begin
        #8_000_000;
        $display("ntc_trimmed_mean_temperature_lookup_unit test failed");
        $finish;
    end

endmodule
